FILE: hw/rtl/bpuv_pkg.sv
// Package for the box projection UV block: widths, face codes and helpers.
// Depends on nothing; used by bpuv_div and box_projection_uv.
package bpuv_pkg;

  localparam int CoordW    = 16;
  localparam int UvFracBits = 15;
  localparam int NormEpsSq = 269;
  localparam int NumCfg    = 6;
  localparam int CfgIdxW   = 3;
  localparam int QuotW     = UvFracBits + 1;
  localparam int DivCntW   = $clog2(QuotW + 1);

  typedef enum logic [2:0] {
    FaceFront  = 3'd0,
    FaceBack   = 3'd1,
    FaceLeft   = 3'd2,
    FaceRight  = 3'd3,
    FaceTop    = 3'd4,
    FaceBottom = 3'd5
  } face_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMinX = 3'd0, CfgMinY = 3'd1, CfgMinZ = 3'd2,
    CfgMaxX = 3'd3, CfgMaxY = 3'd4, CfgMaxZ = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [CoordW-1:0] norm_x;
    logic signed [CoordW-1:0] norm_y;
    logic signed [CoordW-1:0] norm_z;
    logic                     mesh_start;
  } vtx_t;

  typedef struct packed {
    logic [CoordW-1:0] tex_u;
    logic [CoordW-1:0] tex_v;
    logic [2:0]        face_index;
    logic              last_of_triangle;
  } uv_t;

  // Divider handshake between the top level and the serial divider.
  typedef struct packed {
    logic             start;
    logic [CoordW:0]  num;
    logic [CoordW:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
  } div_rsp_t;

endpackage

FILE: hw/rtl/bpuv_if.sv
// Valid/ready channel interface carrying one word of type T.
// Depends on no other file; the word type is given by the parameter T.
interface bpuv_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/bpuv_div.sv
// Restoring bit-serial divider: one quotient bit per cycle.
// Depends on bpuv_pkg; the caller ensures 0 < num < den.
module bpuv_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpuv_pkg::div_req_t  req_i,
  output bpuv_pkg::div_rsp_t  rsp_o
);
  import bpuv_pkg::*;

  logic [CoordW+1:0]  rem_q, rem_d;
  logic [CoordW:0]    den_q, den_d;
  logic [QuotW-1:0]   quot_q, quot_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [CoordW+1:0]  trial;

  // One restoring step: remainder doubles, subtract the divisor if it fits.
  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[CoordW:0], 1'b0};
    if (req_i.start) begin
      rem_d  = {1'b0, req_i.num};
      den_d  = req_i.den;
      quot_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[QuotW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[QuotW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(UvFracBits - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = busy_q && (cnt_q == DivCntW'(UvFracBits - 1));
  assign rsp_o.quot = {quot_q[QuotW-2:0], (trial >= {1'b0, den_q})};

endmodule

FILE: hw/rtl/box_projection_uv.sv
// Box projection UV: top level with sequencer, face choice and output register.
// Depends on bpuv_pkg, bpuv_if and bpuv_div.
//
// Usage: vertex words enter on in_if, three per triangle (mesh_start restarts
// the count). The first two are only stored; the block stays ready for more.
// On the third the block works out the facing direction (normal sum, falling
// back to the edge cross product when the sum is tiny), picks a face and
// produces three UV words on out_if, in vertex order, the last one flagged.
// Each coordinate that does not saturate needs one division by the box size,
// done in a shared bit-serial divider yielding one quotient bit per cycle; a
// saturated coordinate skips it and is set directly. After the third vertex
// the sequencer sums the squared normal length one component at a time, works
// out up to three cross product components, picks the face and then, for each
// vertex, finds both coordinates and loads the result. Results leave through
// an output register; when the receiver stalls, the sequencer waits with the
// next result and no input is taken until the third result is in the output
// register. Reset clears the vertex count, the box registers and the held
// vertices to zero. Box registers are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i, by the user only while the block is idle; it is not enforced.
module box_projection_uv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpuv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bpuv_pkg::CoordW-1:0]   cfg_wdata_i,
  bpuv_if.sink                          in_if,
  bpuv_if.source                        out_if
);
  import bpuv_pkg::*;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StSum   = 7'b0000010,
    StCross = 7'b0000100,
    StFace  = 7'b0001000,
    StPrep  = 7'b0010000,
    StDiv   = 7'b0100000,
    StEmit  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic signed [CoordW-1:0] box_lo_q [3];
  logic signed [CoordW-1:0] box_hi_q [3];
  logic signed [CoordW-1:0] pos_q  [3][3];
  logic signed [CoordW-1:0] nrm_q  [2][3];
  logic [1:0]               vcnt_q;

  // Direction vector: holds normal sum or cross product (cross fits 35 bits).
  logic signed [35:0] dir_q [3];
  logic [2:0]         face_q;
  logic [1:0]         vtx_q;
  logic               axis_q;
  logic [CoordW-1:0]  tu_q;
  logic [CoordW-1:0]  tv_q;
  uv_t                out_q;
  logic               out_valid_q;
  logic [1:0]         xstep_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        box_lo_q[k] <= '0;
        box_hi_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMinX: box_lo_q[0] <= cfg_wdata_i;
        CfgMinY: box_lo_q[1] <= cfg_wdata_i;
        CfgMinZ: box_lo_q[2] <= cfg_wdata_i;
        CfgMaxX: box_hi_q[0] <= cfg_wdata_i;
        CfgMaxY: box_hi_q[1] <= cfg_wdata_i;
        CfgMaxZ: box_hi_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic in_acc, out_acc;
  assign in_if.ready = (state_q == StIdle);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_acc     = out_if.valid && out_if.ready;

  logic [1:0] vslot;
  assign vslot = in_if.data.mesh_start ? 2'd0 : vcnt_q;

  // Squared length of the normal sum, built one component per cycle.
  logic [35:0] sq_acc_q;
  logic [1:0]  sum_k_q;
  logic signed [17:0] comp;
  logic [35:0] comp_sq;
  always_comb begin
    comp = 18'(dir_q[0]);
    unique case (sum_k_q)
      2'd1:    comp = 18'(dir_q[1]);
      2'd2:    comp = 18'(dir_q[2]);
      default: comp = 18'(dir_q[0]);
    endcase
    comp_sq = 36'(comp * comp);
  end

  // Edge vectors and one cross component per cycle.
  logic signed [16:0] e1 [3];
  logic signed [16:0] e2 [3];
  logic signed [33:0] pa, pb;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k] = 17'(pos_q[1][k]) - 17'(pos_q[0][k]);
      e2[k] = 17'(pos_q[2][k]) - 17'(pos_q[0][k]);
    end
    unique case (xstep_q)
      2'd1: begin pa = e1[2] * e2[0]; pb = e1[0] * e2[2]; end
      2'd2: begin pa = e1[0] * e2[1]; pb = e1[1] * e2[0]; end
      default: begin pa = e1[1] * e2[2]; pb = e1[2] * e2[1]; end
    endcase
  end

  // Face choice from the direction vector.
  logic [35:0] ax, ay, az;
  logic [2:0]  face_c;
  always_comb begin
    ax = dir_q[0][35] ? 36'(-dir_q[0]) : 36'(dir_q[0]);
    ay = dir_q[1][35] ? 36'(-dir_q[1]) : 36'(dir_q[1]);
    az = dir_q[2][35] ? 36'(-dir_q[2]) : 36'(dir_q[2]);
    priority if (az >= ax && az >= ay) face_c = dir_q[2][35] ? FaceBottom : FaceTop;
    else if (ay >= ax) face_c = (dir_q[1] <= 0) ? FaceFront : FaceBack;
    else face_c = (dir_q[0] <= 0) ? FaceLeft : FaceRight;
  end

  // Coordinate selection and saturation checks for the current division.
  logic [1:0]         axis_sel;
  logic signed [CoordW-1:0] pcur;
  logic signed [16:0] size_raw, dnum;
  logic [CoordW:0]    size_c;
  logic               sat_lo, sat_hi;
  always_comb begin
    if (face_q >= FaceTop) axis_sel = axis_q ? 2'd1 : 2'd0;
    else if (face_q <= FaceBack) axis_sel = axis_q ? 2'd2 : 2'd0;
    else axis_sel = axis_q ? 2'd2 : 2'd1;
    pcur     = pos_q[vtx_q][axis_sel];
    size_raw = 17'(box_hi_q[axis_sel]) - 17'(box_lo_q[axis_sel]);
    dnum     = 17'(pcur) - 17'(box_lo_q[axis_sel]);
    size_c   = (size_raw < 17'sd1) ? 17'd1 : 17'(size_raw);
    sat_lo   = (dnum <= 17'sd0);
    sat_hi   = !sat_lo && (17'(dnum) >= size_c);
  end

  div_req_t div_req;
  div_rsp_t div_rsp;
  assign div_req.start = (state_q == StPrep) && !sat_lo && !sat_hi;
  assign div_req.num   = 17'(dnum);
  assign div_req.den   = size_c;

  bpuv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Coordinate result and mirroring.
  logic [QuotW-1:0] tcoord;
  logic             coord_rdy;
  logic [CoordW-1:0] tfin;
  always_comb begin
    tcoord    = div_rsp.quot;
    coord_rdy = div_rsp.done;
    if (state_q == StPrep && sat_lo) begin
      tcoord = '0; coord_rdy = 1'b1;
    end else if (state_q == StPrep && sat_hi) begin
      tcoord = QuotW'(1) << UvFracBits; coord_rdy = 1'b1;
    end
    if (!axis_q && face_q[0]) tfin = CoordW'((QuotW'(1) << UvFracBits) - tcoord);
    else tfin = CoordW'(tcoord);
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_acc && vslot == 2'd2) state_d = StSum;
      StSum:   if (sum_k_q == 2'd2) state_d = StCross;
      StCross: if (sq_acc_q >= 36'(NormEpsSq) || xstep_q == 2'd2) state_d = StFace;
      StFace:  state_d = StPrep;
      StPrep:  state_d = coord_rdy ? (axis_q ? StEmit : StPrep) : StDiv;
      StDiv:   if (coord_rdy) state_d = axis_q ? StEmit : StPrep;
      StEmit:  if (!out_valid_q || out_acc) state_d = (vtx_q == 2'd2) ? StIdle : StPrep;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      vcnt_q      <= '0;
      out_valid_q <= 1'b0;
      sum_k_q     <= '0;
      xstep_q     <= '0;
      vtx_q       <= '0;
      axis_q      <= 1'b0;
      tu_q        <= '0;
      tv_q        <= '0;
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++) pos_q[i][k] <= '0;
      for (int i = 0; i < 2; i++)
        for (int k = 0; k < 3; k++) nrm_q[i][k] <= '0;
    end else begin
      state_q <= state_d;
      // A taken word frees the output register unless a new one is loaded.
      if (out_acc && state_q != StEmit) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: if (in_acc) begin
          pos_q[vslot][0] <= in_if.data.pos_x;
          pos_q[vslot][1] <= in_if.data.pos_y;
          pos_q[vslot][2] <= in_if.data.pos_z;
          if (vslot != 2'd2) begin
            nrm_q[vslot[0]][0] <= in_if.data.norm_x;
            nrm_q[vslot[0]][1] <= in_if.data.norm_y;
            nrm_q[vslot[0]][2] <= in_if.data.norm_z;
            vcnt_q <= vslot + 2'd1;
          end else begin
            vcnt_q <= '0;
          end
          sum_k_q <= '0;
          xstep_q <= '0;
        end
        StSum:   sum_k_q <= sum_k_q + 2'd1;
        StCross: xstep_q <= xstep_q + 2'd1;
        StFace: begin
          vtx_q  <= '0;
          axis_q <= 1'b0;
        end
        StPrep, StDiv: if (coord_rdy) begin
          if (!axis_q) tu_q <= tfin;
          else tv_q <= tfin;
          axis_q <= ~axis_q;
        end
        StEmit: if (!out_valid_q || out_acc) begin
          out_valid_q <= 1'b1;
          vtx_q <= vtx_q + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers: direction vector, face, output word.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: if (in_acc) begin
        dir_q[0] <= 36'(nrm_q[0][0]) + 36'(nrm_q[1][0]) + 36'(in_if.data.norm_x);
        dir_q[1] <= 36'(nrm_q[0][1]) + 36'(nrm_q[1][1]) + 36'(in_if.data.norm_y);
        dir_q[2] <= 36'(nrm_q[0][2]) + 36'(nrm_q[1][2]) + 36'(in_if.data.norm_z);
        sq_acc_q <= '0;
      end
      StSum: sq_acc_q <= sq_acc_q + comp_sq;
      StCross: if (sq_acc_q < 36'(NormEpsSq)) dir_q[xstep_q] <= 36'(pa) - 36'(pb);
      StFace: face_q <= face_c;
      StEmit: if (!out_valid_q || out_acc) begin
        out_q.tex_u            <= tu_q;
        out_q.tex_v            <= tv_q;
        out_q.face_index       <= face_q;
        out_q.last_of_triangle <= (vtx_q == 2'd2);
      end
      default: ;
    endcase
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  // Input is only taken while the sequencer is idle.
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && state_q != StIdle |-> !in_if.ready) else $error("input taken while busy");
  // A pending result is never dropped: valid stays high until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid) else $error("result dropped");
  // Face index stays within the six faces.
  a_face_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.data.face_index <= FaceBottom) else $error("bad face");
  // Divider only finishes while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == StDiv) else $error("stray divider result");

endmodule
